FILE: src/assert_macros.svh
// Assertion helper macros for the seven-segment scan clock checker.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while the active-low reset is asserted.
`define ASSERT_CLKD(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error(msg);

// Condition that must never be true on a sampled clock edge.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  `ASSERT_CLKD(label, clk, rst_n, !(cond), msg)

`endif

FILE: src/msc_pkg.sv
// Shared types, constants and decode functions for the scan clock block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package msc_pkg;

  localparam int unsigned TIMER_W     = 16;
  localparam int unsigned DIGIT_COUNT = 4;
  localparam int unsigned SLOT_W      = $clog2(DIGIT_COUNT);
  localparam int unsigned HOUR_W      = 5;
  localparam int unsigned MIN_W       = 6;
  localparam int unsigned SEG_W       = 7;
  localparam int unsigned APB_AW      = 4;
  localparam int unsigned APB_DW      = 32;

  localparam logic [TIMER_W-1:0] RED_PERIOD_RST  = 16'd200;
  localparam logic [TIMER_W-1:0] DOT_PERIOD_RST  = 16'd100;
  localparam logic [TIMER_W-1:0] SCAN_PERIOD_RST = 16'd25;

  localparam logic [HOUR_W-1:0] HOUR_RST   = 5'd15;
  localparam logic [MIN_W-1:0]  MINUTE_RST = 6'd8;
  localparam logic [MIN_W-1:0]  SECOND_RST = 6'd50;

  localparam logic [HOUR_W-1:0] HOUR_LAST = 5'd23;
  localparam logic [MIN_W-1:0]  MIN_LAST  = 6'd59;

  typedef enum logic [1:0] {
    REG_RED_PERIOD  = 2'd0,
    REG_DOT_PERIOD  = 2'd1,
    REG_SCAN_PERIOD = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [TIMER_W-1:0] red_period;
    logic [TIMER_W-1:0] dot_period;
    logic [TIMER_W-1:0] scan_period;
  } cfg_t;

  typedef struct packed {
    logic red;
    logic dot;
    logic scan;
  } fire_t;

  typedef struct packed {
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [MIN_W-1:0]  second;
  } time_t;

  // Tens digit of a value below 60.
  function automatic logic [3:0] tens_of(input logic [MIN_W-1:0] v);
    logic [3:0] t;
    if (v >= 6'd50)      t = 4'd5;
    else if (v >= 6'd40) t = 4'd4;
    else if (v >= 6'd30) t = 4'd3;
    else if (v >= 6'd20) t = 4'd2;
    else if (v >= 6'd10) t = 4'd1;
    else                 t = 4'd0;
    return t;
  endfunction

  // Units digit of a value below 60.
  function automatic logic [3:0] units_of(input logic [MIN_W-1:0] v);
    logic [MIN_W-1:0] tens10;
    logic [MIN_W-1:0] rem;
    tens10 = MIN_W'(tens_of(v)) * 6'd10;
    rem    = v - tens10;
    return rem[3:0];
  endfunction

  // Active-low segment pattern, segment a in bit 0.
  function automatic logic [SEG_W-1:0] seg_encode(input logic [3:0] d);
    logic [SEG_W-1:0] s;
    case (d)
      4'd0:    s = 7'h40;
      4'd1:    s = 7'h79;
      4'd2:    s = 7'h24;
      4'd3:    s = 7'h30;
      4'd4:    s = 7'h19;
      4'd5:    s = 7'h12;
      4'd6:    s = 7'h02;
      4'd7:    s = 7'h78;
      4'd8:    s = 7'h00;
      4'd9:    s = 7'h10;
      default: s = 7'h7F;
    endcase
    return s;
  endfunction

endpackage

FILE: src/msc_timer.sv
// Countdown timer that fires and reloads its period on the step that would take it to zero.
// Depends on msc_pkg for the counter width.
`timescale 1ns / 1ps

module msc_timer import msc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic [TIMER_W-1:0] period_i,
  output logic               fire_o
);

  logic [TIMER_W-1:0] left_q, left_d;

  // A timer sitting at zero is dead: it neither counts nor fires.
  assign fire_o = step_i && (left_q == TIMER_W'(1));

  always_comb begin
    left_d = left_q;
    if (fire_o) begin
      left_d = period_i;
    end else if (step_i && (left_q != '0)) begin
      left_d = left_q - TIMER_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= TIMER_W'(1);
    end else begin
      left_q <= left_d;
    end
  end

endmodule

FILE: src/msc_scan.sv
// Digit scan and time-of-day counter: drives one digit per scan step and
// advances the clock by one second on the last digit's step. Depends on msc_pkg.
`timescale 1ns / 1ps

module msc_scan import msc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  output time_t                  time_o,
  output logic [DIGIT_COUNT-1:0] enable_n_o,
  output logic [SEG_W-1:0]       segments_n_o
);

  logic [SLOT_W-1:0]      slot_q, slot_d;
  time_t                  time_q, time_d;
  logic [DIGIT_COUNT-1:0] enable_n_q, enable_n_d;
  logic [SEG_W-1:0]       seg_q, seg_d;
  logic [3:0]             digit;
  logic                   last_slot;

  // Digit of the current time for this slot, taken before the second advances.
  always_comb begin
    case (slot_q)
      2'd0:    digit = tens_of(MIN_W'(time_q.hour));
      2'd1:    digit = units_of(MIN_W'(time_q.hour));
      2'd2:    digit = tens_of(time_q.minute);
      default: digit = units_of(time_q.minute);
    endcase
  end

  assign last_slot = (slot_q == SLOT_W'(DIGIT_COUNT - 1));

  always_comb begin
    slot_d     = slot_q;
    time_d     = time_q;
    enable_n_d = enable_n_q;
    seg_d      = seg_q;
    if (step_i) begin
      enable_n_d = ~(DIGIT_COUNT'(1) << slot_q);
      seg_d      = seg_encode(digit);
      if (last_slot) begin
        slot_d = '0;
        if (time_q.second == MIN_LAST) begin
          time_d.second = '0;
          if (time_q.minute == MIN_LAST) begin
            time_d.minute = '0;
            time_d.hour   = (time_q.hour == HOUR_LAST) ? '0 : time_q.hour + HOUR_W'(1);
          end else begin
            time_d.minute = time_q.minute + MIN_W'(1);
          end
        end else begin
          time_d.second = time_q.second + MIN_W'(1);
        end
      end else begin
        slot_d = slot_q + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q        <= '0;
      time_q.hour   <= HOUR_RST;
      time_q.minute <= MINUTE_RST;
      time_q.second <= SECOND_RST;
      enable_n_q    <= '0;
      seg_q         <= '0;
    end else begin
      slot_q     <= slot_d;
      time_q     <= time_d;
      enable_n_q <= enable_n_d;
      seg_q      <= seg_d;
    end
  end

  assign time_o       = time_q;
  assign enable_n_o   = enable_n_q;
  assign segments_n_o = seg_q;

endmodule

FILE: src/msc_regs.sv
// APB register file holding the three timer periods.
// Depends on msc_pkg for the register map and the cfg_t bundle.
`timescale 1ns / 1ps

module msc_regs import msc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_RED_PERIOD:  cfg_d.red_period  = pwdata[TIMER_W-1:0];
        REG_DOT_PERIOD:  cfg_d.dot_period  = pwdata[TIMER_W-1:0];
        REG_SCAN_PERIOD: cfg_d.scan_period = pwdata[TIMER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_RED_PERIOD:  prdata = APB_DW'(cfg_q.red_period);
      REG_DOT_PERIOD:  prdata = APB_DW'(cfg_q.dot_period);
      REG_SCAN_PERIOD: prdata = APB_DW'(cfg_q.scan_period);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.red_period  <= RED_PERIOD_RST;
      cfg_q.dot_period  <= DOT_PERIOD_RST;
      cfg_q.scan_period <= SCAN_PERIOD_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: src/multiplexed_seven_segment_clock.sv
// Top level of the four-digit seven-segment scan clock with two LEDs.
// Depends on msc_pkg, msc_regs, msc_timer and msc_scan.
`timescale 1ns / 1ps

// Usage:
//  - Input channel (in_valid_i / in_ready_o, field tick_i): one item per
//    10 ms timebase event. tick 1 advances the red, dot and scan timers;
//    tick 0 leaves all state alone and just reports it.
//  - Output channel (out_valid_o / out_ready_i): exactly one item per input
//    item, showing digit enables, segments, LED levels and the time of day
//    as they stand after that input item.
//  - The item accepted at an edge is offered at the output right after it.
//    Throughput is one item per cycle; the state registers double as the
//    output register, so in_ready_o follows out_ready_i whenever a result
//    is pending.
//  - When the receiver stalls, the pending result holds and no new item is
//    taken, so the state cannot run ahead of what was reported.
//  - APB port: red, dot and scan periods at byte addresses 0, 4 and 8.
//    A write takes effect at the next reload of that timer.
//  - Reset: periods 200/100/25, all timers at one tick (all fire on the
//    first tick), LEDs off, all digits and segments driven low, time 15:08:50.
module multiplexed_seven_segment_clock import msc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   tick_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [DIGIT_COUNT-1:0] digit_enable_n_o,
  output logic [SEG_W-1:0]       segments_n_o,
  output logic                   red_led_o,
  output logic                   dot_led_o,
  output logic [HOUR_W-1:0]      clock_hour_o,
  output logic [MIN_W-1:0]       clock_minute_o,
  output logic [MIN_W-1:0]       clock_second_o,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_AW-1:0]      paddr,
  input  logic [APB_DW-1:0]      pwdata,
  output logic [APB_DW-1:0]      prdata,
  output logic                   pready
);

  cfg_t  cfg;
  fire_t fire;
  time_t now;
  logic  accept;
  logic  step;
  logic  out_valid_q, out_valid_d;
  logic  red_q, red_d;
  logic  dot_q, dot_d;

  // Take a new item when the result slot is empty or being drained.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign step       = accept && tick_i;

  msc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  msc_timer u_red_timer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .period_i (cfg.red_period),
    .fire_o   (fire.red)
  );

  msc_timer u_dot_timer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .period_i (cfg.dot_period),
    .fire_o   (fire.dot)
  );

  msc_timer u_scan_timer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .period_i (cfg.scan_period),
    .fire_o   (fire.scan)
  );

  msc_scan u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (fire.scan),
    .time_o       (now),
    .enable_n_o   (digit_enable_n_o),
    .segments_n_o (segments_n_o)
  );

  // Toggle each LED when its timer fires.
  assign red_d = red_q ^ fire.red;
  assign dot_d = dot_q ^ fire.dot;

  // Raise valid on accept, drop it once the result is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      red_q       <= 1'b0;
      dot_q       <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      red_q       <= red_d;
      dot_q       <= dot_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign red_led_o      = red_q;
  assign dot_led_o      = dot_q;
  assign clock_hour_o   = now.hour;
  assign clock_minute_o = now.minute;
  assign clock_second_o = now.second;

endmodule

FILE: src/msc_checker.sv
// Port-level checker for the scan clock, bound to the top level.
// Depends on msc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module msc_checker import msc_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input logic                   tick_i,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic [DIGIT_COUNT-1:0] digit_enable_n_o,
  input logic [HOUR_W-1:0]      clock_hour_o,
  input logic [MIN_W-1:0]       clock_minute_o,
  input logic [MIN_W-1:0]       clock_second_o
);

  // A stalled result keeps its valid, its seconds field and its digit enables.
  `ASSERT_CLKD(a_stall_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(clock_second_o) && $stable(digit_enable_n_o), "stalled result changed")

  // Time of day stays within range.
  `ASSERT_NEVER(a_time_range, clk_i, rst_ni, clock_hour_o > HOUR_LAST || clock_minute_o > MIN_LAST || clock_second_o > MIN_LAST, "time out of range")

  // Exactly one digit enabled, except the all-enabled reset pattern.
  `ASSERT_CLKD(a_one_digit, clk_i, rst_ni, digit_enable_n_o == '0 || $onehot(~digit_enable_n_o), "more than one digit driven")

  // An idle item yields a result with unchanged seconds, minutes and digit enables.
  `ASSERT_CLKD(a_idle_item, clk_i, rst_ni, in_valid_i && in_ready_o && !tick_i |=> out_valid_o && $stable(clock_second_o) && $stable(clock_minute_o) && $stable(digit_enable_n_o), "idle item changed state")

endmodule

bind multiplexed_seven_segment_clock msc_checker u_msc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .tick_i           (tick_i),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .digit_enable_n_o (digit_enable_n_o),
  .clock_hour_o     (clock_hour_o),
  .clock_minute_o   (clock_minute_o),
  .clock_second_o   (clock_second_o)
);
